// ===== src/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types, codes and defaults of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // Default sizing of the segment table and of the byte region.
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int REGION_BYTES_DEF = 65536;

  // Request kinds.
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_REALLOC = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BADADDR = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [6:0]  HEADER_RST = 7'd16;
  localparam logic [16:0] LIMIT_RST  = 17'd65536;

  // Sequencer steps; each step is also the command handed to the datapath.
  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] C_IDLE  = 5'd0;
  localparam logic [CMD_W-1:0] C_DISP  = 5'd1;
  localparam logic [CMD_W-1:0] C_FU_RD = 5'd2;
  localparam logic [CMD_W-1:0] C_FU_EV = 5'd3;
  localparam logic [CMD_W-1:0] C_FF_RD = 5'd4;
  localparam logic [CMD_W-1:0] C_FF_EV = 5'd5;
  localparam logic [CMD_W-1:0] C_APND  = 5'd6;
  localparam logic [CMD_W-1:0] C_FAIL  = 5'd7;
  localparam logic [CMD_W-1:0] C_G0    = 5'd8;
  localparam logic [CMD_W-1:0] C_G1    = 5'd9;
  localparam logic [CMD_W-1:0] C_SU_RD = 5'd10;
  localparam logic [CMD_W-1:0] C_SU_EV = 5'd11;
  localparam logic [CMD_W-1:0] C_T_RD  = 5'd12;
  localparam logic [CMD_W-1:0] C_T_EV  = 5'd13;
  localparam logic [CMD_W-1:0] C_R0    = 5'd14;
  localparam logic [CMD_W-1:0] C_R1    = 5'd15;
  localparam logic [CMD_W-1:0] C_R2    = 5'd16;
  localparam logic [CMD_W-1:0] C_SD_RD = 5'd17;
  localparam logic [CMD_W-1:0] C_SD_EV = 5'd18;
  localparam logic [CMD_W-1:0] C_ZERO  = 5'd19;
  localparam logic [CMD_W-1:0] C_BAD   = 5'd20;
  localparam logic [CMD_W-1:0] C_RG    = 5'd21;
  localparam logic [CMD_W-1:0] C_GR    = 5'd22;
  localparam logic [CMD_W-1:0] C_AFT   = 5'd23;
  localparam logic [CMD_W-1:0] C_FIN   = 5'd24;

  // One row of the segment table.
  typedef struct packed {
    logic [15:0] off;
    logic [16:0] size;
    logic        free;
  } seg_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       has;
    logic       req_zero;
    logic       ptr_end;
    logic       fu_hit;
    logic       ff_hit;
    logic       fits;
    logic       can_append;
    logic       split_ok;
    logic       merge_ok;
    logic       su_done;
    logic       cnt_zero;
    logic       top_free;
    logic       sd_done;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== src/first_fit_segment_allocator.sv =====
// A request reads and then evaluates each table row that the sequencer
// visits over the single read port of the segment table. A free of
// a null address or an unused kind goes from dispatch straight to the
// finish step. A reallocate that moves its segment runs two address
// searches, a first-fit search, an insert, a removal and two top trims.
// Each of these visits up to MAX_SEGMENTS rows. One request is in the
// block at a time. The finished result waits in an output register, so
// the next request is taken while that result is still stalled. The
// table needs no clearing after reset.
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over a byte region with split, coalesce and realloc.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int REGION_BYTES = ffsa_pkg::REGION_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [16:0] in_request_size,
  input  logic        in_has_address,
  input  logic [15:0] in_block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_result_address,
  output logic        out_moved,
  output logic [16:0] out_copy_bytes,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata
);

  logic [ffsa_pkg::CMD_W-1:0] cmd;
  ffsa_pkg::dp_status_t       st;

  // Sequencer.
  ffsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Table, arithmetic and result register.
  ffsa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .REGION_BYTES (REGION_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_kind            (in_kind),
    .in_request_size    (in_request_size),
    .in_has_address     (in_has_address),
    .in_block_address   (in_block_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_moved          (out_moved),
    .out_copy_bytes     (out_copy_bytes)
  );

endmodule

// ===== src/ffsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer of the allocator: walks the steps of each request and issues
// one datapath command per cycle.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffsa_pkg::dp_status_t         st,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic [ffsa_pkg::CMD_W-1:0]   cmd
);

  // What follows once a grant, append or release has finished.
  localparam logic [2:0] J_ALLOC   = 3'd0;
  localparam logic [2:0] J_FREE    = 3'd1;
  localparam logic [2:0] J_REAL    = 3'd2;
  localparam logic [2:0] J_REGRANT = 3'd3;
  localparam logic [2:0] J_GROW    = 3'd4;
  localparam logic [2:0] J_GROWREL = 3'd5;

  logic [ffsa_pkg::CMD_W-1:0] state_r, state_nxt;
  logic [2:0]                 job_r, job_nxt;

  assign cmd      = state_r;
  assign in_stall = (state_r != ffsa_pkg::C_IDLE);

  // Next-step selection.
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    case (state_r)
      ffsa_pkg::C_IDLE: begin
        if (in_valid) state_nxt = ffsa_pkg::C_DISP;
      end
      ffsa_pkg::C_DISP: begin
        case (st.kind)
          ffsa_pkg::KIND_ALLOC: begin
            job_nxt   = J_ALLOC;
            state_nxt = st.req_zero ? ffsa_pkg::C_ZERO : ffsa_pkg::C_FF_RD;
          end
          ffsa_pkg::KIND_FREE: begin
            job_nxt   = J_FREE;
            state_nxt = st.has ? ffsa_pkg::C_FU_RD : ffsa_pkg::C_FIN;
          end
          ffsa_pkg::KIND_REALLOC: begin
            if (st.has) begin
              job_nxt   = J_REAL;
              state_nxt = ffsa_pkg::C_FU_RD;
            end else begin
              job_nxt   = J_ALLOC;
              state_nxt = st.req_zero ? ffsa_pkg::C_ZERO : ffsa_pkg::C_FF_RD;
            end
          end
          default: state_nxt = ffsa_pkg::C_FIN;
        endcase
      end
      ffsa_pkg::C_FU_RD: begin
        if (st.ptr_end)
          state_nxt = (job_r == J_GROWREL) ? ffsa_pkg::C_FIN : ffsa_pkg::C_BAD;
        else
          state_nxt = ffsa_pkg::C_FU_EV;
      end
      ffsa_pkg::C_FU_EV: begin
        if (!st.fu_hit) begin
          state_nxt = ffsa_pkg::C_FU_RD;
        end else if (job_r == J_REAL) begin
          if (st.req_zero) begin
            state_nxt = ffsa_pkg::C_ZERO;
          end else if (st.fits) begin
            job_nxt   = J_REGRANT;
            state_nxt = ffsa_pkg::C_RG;
          end else begin
            job_nxt   = J_GROW;
            state_nxt = ffsa_pkg::C_GR;
          end
        end else begin
          state_nxt = ffsa_pkg::C_R0;
        end
      end
      ffsa_pkg::C_RG: state_nxt = ffsa_pkg::C_G0;
      ffsa_pkg::C_GR: state_nxt = ffsa_pkg::C_FF_RD;
      ffsa_pkg::C_FF_RD: begin
        if (!st.ptr_end)        state_nxt = ffsa_pkg::C_FF_EV;
        else if (st.can_append) state_nxt = ffsa_pkg::C_APND;
        else                    state_nxt = ffsa_pkg::C_FAIL;
      end
      ffsa_pkg::C_FF_EV: begin
        state_nxt = st.ff_hit ? ffsa_pkg::C_G0 : ffsa_pkg::C_FF_RD;
      end
      ffsa_pkg::C_APND: state_nxt = ffsa_pkg::C_AFT;
      ffsa_pkg::C_G0: begin
        state_nxt = st.split_ok ? ffsa_pkg::C_G1 : ffsa_pkg::C_AFT;
      end
      ffsa_pkg::C_G1: begin
        state_nxt = st.merge_ok ? ffsa_pkg::C_T_RD : ffsa_pkg::C_SU_RD;
      end
      ffsa_pkg::C_SU_RD: begin
        state_nxt = st.su_done ? ffsa_pkg::C_T_RD : ffsa_pkg::C_SU_EV;
      end
      ffsa_pkg::C_SU_EV: state_nxt = ffsa_pkg::C_SU_RD;
      ffsa_pkg::C_T_RD: begin
        state_nxt = st.cnt_zero ? ffsa_pkg::C_AFT : ffsa_pkg::C_T_EV;
      end
      ffsa_pkg::C_T_EV: begin
        state_nxt = st.top_free ? ffsa_pkg::C_T_RD : ffsa_pkg::C_AFT;
      end
      ffsa_pkg::C_R0: state_nxt = ffsa_pkg::C_R1;
      ffsa_pkg::C_R1: state_nxt = ffsa_pkg::C_R2;
      ffsa_pkg::C_R2: state_nxt = ffsa_pkg::C_SD_RD;
      ffsa_pkg::C_SD_RD: begin
        state_nxt = st.sd_done ? ffsa_pkg::C_T_RD : ffsa_pkg::C_SD_EV;
      end
      ffsa_pkg::C_SD_EV: state_nxt = ffsa_pkg::C_SD_RD;
      ffsa_pkg::C_AFT: begin
        if (job_r == J_GROW) begin
          job_nxt   = J_GROWREL;
          state_nxt = ffsa_pkg::C_FU_RD;
        end else begin
          state_nxt = ffsa_pkg::C_FIN;
        end
      end
      ffsa_pkg::C_FAIL: state_nxt = ffsa_pkg::C_FIN;
      ffsa_pkg::C_ZERO: state_nxt = ffsa_pkg::C_FIN;
      ffsa_pkg::C_BAD:  state_nxt = ffsa_pkg::C_FIN;
      ffsa_pkg::C_FIN: begin
        if (st.out_free) state_nxt = ffsa_pkg::C_IDLE;
      end
      default: state_nxt = ffsa_pkg::C_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffsa_pkg::C_IDLE;
      job_r   <= J_ALLOC;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

endmodule

// ===== src/ffsa_dp.sv =====
// ----------------------------------------------------------------------------
// ffsa_dp
// Datapath of the allocator: segment table memory, count and top registers,
// configuration, arithmetic and the result register.
// ----------------------------------------------------------------------------
module ffsa_dp #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int REGION_BYTES = ffsa_pkg::REGION_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ffsa_pkg::CMD_W-1:0]   cmd,
  output ffsa_pkg::dp_status_t         st,
  input  logic [1:0]                   in_kind,
  input  logic [16:0]                  in_request_size,
  input  logic                         in_has_address,
  input  logic [15:0]                  in_block_address,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [16:0]                  cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_status,
  output logic [15:0]                  out_result_address,
  output logic                         out_moved,
  output logic [16:0]                  out_copy_bytes
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
  localparam int LIM_CAP_I = (REGION_BYTES < 65536) ? REGION_BYTES : 65536;
  localparam logic [16:0] LIM_CAP = 17'(LIM_CAP_I);

  // Segment table.
  ffsa_pkg::seg_t mem [MAX_SEGMENTS];
  ffsa_pkg::seg_t rd_r;
  logic [IW-1:0]  raddr;
  logic           we;
  logic [IW-1:0]  waddr;
  ffsa_pkg::seg_t wdata;

  // Control and working registers.
  logic [6:0]    hdr_r;
  logic [16:0]   lim_r;
  logic [CW-1:0] cnt_r;
  logic [16:0]   used_r;
  logic [CW-1:0] ptr_r;
  logic [IW-1:0] idx_r;
  logic [1:0]    d_r;
  logic [1:0]    kind_r;
  logic [16:0]   req_r;
  logic          has_r;
  logic [15:0]   addr_r;
  logic [15:0]   e_off_r;
  logic [16:0]   e_size_r;
  logic [15:0]   n_off_r;
  logic [16:0]   n_size_r;
  logic [16:0]   old_size_r;
  logic [2:0]    status_r;
  logic [15:0]   res_r;
  logic          moved_r;
  logic [16:0]   copy_r;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [15:0]   out_res_r;
  logic          out_moved_r;
  logic [16:0]   out_copy_r;

  // Derived values.
  logic [IW-1:0] idx_p1, idx_m1;
  logic [CW-1:0] idx_p1_c;
  logic [CW:0]   ptr_pd;
  logic [18:0]   need;
  logic [16:0]   lim_eff;
  logic [15:0]   app_off;
  logic [16:0]   diff;
  logic          grow;
  logic          nf, pf;
  logic [16:0]   trim_used;

  assign idx_p1    = idx_r + IW'(1);
  assign idx_m1    = idx_r - IW'(1);
  assign idx_p1_c  = CW'(idx_r) + CW'(1);
  assign ptr_pd    = {1'b0, ptr_r} + (CW+1)'(d_r);
  assign need      = 19'(used_r) + 19'(hdr_r) + 19'(req_r);
  assign lim_eff   = (lim_r < LIM_CAP) ? lim_r : LIM_CAP;
  assign app_off   = used_r[15:0] + 16'(hdr_r);
  assign diff      = e_size_r - req_r;
  assign grow      = (kind_r == ffsa_pkg::KIND_REALLOC) && has_r;
  assign nf        = (idx_p1_c < cnt_r) && rd_r.free;
  assign pf        = (idx_r != '0) && rd_r.free;
  assign trim_used = (rd_r.off > 16'(hdr_r)) ? (17'(rd_r.off) - 17'(hdr_r)) : 17'd0;

  // Status towards the controller.
  always_comb begin
    st.kind       = kind_r;
    st.has        = has_r;
    st.req_zero   = (req_r == '0);
    st.ptr_end    = (ptr_r == cnt_r);
    st.fu_hit     = !rd_r.free && (rd_r.off == addr_r);
    st.ff_hit     = rd_r.free && (rd_r.size >= req_r);
    st.fits       = (req_r <= rd_r.size);
    st.can_append = (cnt_r < MAX_CNT) && (need <= 19'(lim_eff));
    st.split_ok   = (diff > 17'(hdr_r)) && (cnt_r < MAX_CNT);
    st.merge_ok   = nf;
    st.su_done    = (ptr_r == idx_p1_c);
    st.cnt_zero   = (cnt_r == '0);
    st.top_free   = rd_r.free;
    st.sd_done    = (ptr_pd >= {1'b0, cnt_r});
    st.out_free   = !out_valid_r || !out_stall;
  end

  // Table read address for the step.
  always_comb begin
    case (cmd)
      ffsa_pkg::C_G0, ffsa_pkg::C_R0: raddr = idx_p1;
      ffsa_pkg::C_R1:                 raddr = idx_m1;
      ffsa_pkg::C_SU_RD:              raddr = ptr_r[IW-1:0] - IW'(1);
      ffsa_pkg::C_T_RD:               raddr = cnt_r[IW-1:0] - IW'(1);
      ffsa_pkg::C_SD_RD:              raddr = ptr_pd[IW-1:0];
      default:                        raddr = ptr_r[IW-1:0];
    endcase
  end

  // Table write for the step.
  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = rd_r;
    case (cmd)
      ffsa_pkg::C_G0: begin
        we    = 1'b1;
        wdata = '{off: e_off_r, size: st.split_ok ? req_r : e_size_r, free: 1'b0};
      end
      ffsa_pkg::C_G1: begin
        we    = nf;
        waddr = idx_p1;
        wdata = '{off: n_off_r, size: n_size_r + 17'(hdr_r) + rd_r.size, free: 1'b1};
      end
      ffsa_pkg::C_SU_RD: begin
        we    = st.su_done;
        waddr = idx_p1;
        wdata = '{off: n_off_r, size: n_size_r, free: 1'b1};
      end
      ffsa_pkg::C_SU_EV, ffsa_pkg::C_SD_EV: begin
        we    = 1'b1;
        waddr = ptr_r[IW-1:0];
      end
      ffsa_pkg::C_APND: begin
        we    = 1'b1;
        waddr = cnt_r[IW-1:0];
        wdata = '{off: app_off, size: req_r, free: 1'b0};
      end
      ffsa_pkg::C_R2: begin
        we = 1'b1;
        if (pf) begin
          waddr = idx_m1;
          wdata = '{off: rd_r.off, size: rd_r.size + 17'(hdr_r) + n_size_r, free: 1'b1};
        end else begin
          wdata = '{off: e_off_r, size: n_size_r, free: 1'b1};
        end
      end
      default: we = 1'b0;
    endcase
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  // Working registers, updated per step.
  always_ff @(posedge clk) begin
    case (cmd)
      ffsa_pkg::C_IDLE: begin
        kind_r   <= in_kind;
        req_r    <= in_request_size;
        has_r    <= in_has_address;
        addr_r   <= in_block_address;
        status_r <= ffsa_pkg::ST_OK;
        res_r    <= '0;
        moved_r  <= 1'b0;
        copy_r   <= '0;
      end
      ffsa_pkg::C_DISP, ffsa_pkg::C_AFT: ptr_r <= '0;
      ffsa_pkg::C_GR: begin
        ptr_r      <= '0;
        old_size_r <= e_size_r;
      end
      ffsa_pkg::C_RG: res_r <= addr_r;
      ffsa_pkg::C_FU_EV: begin
        if (st.fu_hit) begin
          idx_r    <= ptr_r[IW-1:0];
          e_off_r  <= rd_r.off;
          e_size_r <= rd_r.size;
        end else begin
          ptr_r <= ptr_r + CW'(1);
        end
      end
      ffsa_pkg::C_FF_EV: begin
        if (st.ff_hit) begin
          idx_r    <= ptr_r[IW-1:0];
          e_off_r  <= rd_r.off;
          e_size_r <= rd_r.size;
          res_r    <= rd_r.off;
          if (grow) begin
            moved_r <= 1'b1;
            copy_r  <= old_size_r;
          end
        end else begin
          ptr_r <= ptr_r + CW'(1);
        end
      end
      ffsa_pkg::C_APND: begin
        res_r <= app_off;
        if (grow) begin
          moved_r <= 1'b1;
          copy_r  <= old_size_r;
        end
      end
      ffsa_pkg::C_FAIL: begin
        status_r <= (cnt_r >= MAX_CNT) ? ffsa_pkg::ST_FULL : ffsa_pkg::ST_NOSPACE;
        res_r    <= grow ? addr_r : 16'd0;
      end
      ffsa_pkg::C_ZERO: begin
        status_r <= ffsa_pkg::ST_ZERO;
        res_r    <= grow ? addr_r : 16'd0;
      end
      ffsa_pkg::C_BAD: status_r <= ffsa_pkg::ST_BADADDR;
      ffsa_pkg::C_G0: begin
        n_off_r  <= e_off_r + req_r[15:0] + 16'(hdr_r);
        n_size_r <= diff - 17'(hdr_r);
      end
      ffsa_pkg::C_G1: begin
        if (!nf) ptr_r <= cnt_r;
      end
      ffsa_pkg::C_SU_EV: ptr_r <= ptr_r - CW'(1);
      ffsa_pkg::C_R1: begin
        n_size_r <= nf ? (e_size_r + 17'(hdr_r) + rd_r.size) : e_size_r;
        d_r      <= {1'b0, nf};
      end
      ffsa_pkg::C_R2: begin
        if (pf) begin
          ptr_r <= CW'(idx_r);
          d_r   <= d_r + 2'd1;
        end else begin
          ptr_r <= idx_p1_c;
        end
      end
      ffsa_pkg::C_SD_EV: ptr_r <= ptr_r + CW'(1);
      default: ;
    endcase
  end

  // Count, top of the used area and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      used_r <= '0;
      hdr_r  <= ffsa_pkg::HEADER_RST;
      lim_r  <= ffsa_pkg::LIMIT_RST;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ffsa_pkg::CFG_HEADER) hdr_r <= cfg_wdata[6:0];
        else                                   lim_r <= cfg_wdata;
      end
      case (cmd)
        ffsa_pkg::C_APND: begin
          cnt_r  <= cnt_r + CW'(1);
          used_r <= need[16:0];
        end
        ffsa_pkg::C_SU_RD: begin
          if (st.su_done) cnt_r <= cnt_r + CW'(1);
        end
        ffsa_pkg::C_T_EV: begin
          if (rd_r.free) begin
            cnt_r  <= cnt_r - CW'(1);
            used_r <= trim_used;
          end
        end
        ffsa_pkg::C_SD_RD: begin
          if (st.sd_done) cnt_r <= cnt_r - CW'(d_r);
        end
        default: ;
      endcase
    end
  end

  // Result register: one beat waits here while the next request runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == ffsa_pkg::C_FIN && st.out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == ffsa_pkg::C_FIN && st.out_free) begin
      out_status_r <= status_r;
      out_res_r    <= res_r;
      out_moved_r  <= moved_r;
      out_copy_r   <= copy_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_res_r;
  assign out_moved          = out_moved_r;
  assign out_copy_bytes     = out_copy_r;

`ifndef NO_ASSERTIONS
  // The table never holds more segments than it has rows.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT) else $error("segment count above table depth");

  // Opening a slot grows the table by exactly one segment.
  a_open_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == ffsa_pkg::C_SU_RD && st.su_done) |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("slot insert did not grow the table");

  // Handing back a free top segment shrinks the table by one.
  a_trim: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == ffsa_pkg::C_T_EV && rd_r.free) |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("top trim did not shrink the table");

  // A delivered result only carries a defined status code.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r <= ffsa_pkg::ST_BADADDR)
    else $error("undefined status code on result");
`endif

endmodule

// ===== tb/sv/tb_first_fit_segment_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_segment_allocator
// Drives allocate, free and reallocate requests into the segment allocator,
// keeps its own copy of the segment table to work out the expected beat for
// every request, and checks each result beat field by field in order.
// ----------------------------------------------------------------------------
module tb_first_fit_segment_allocator;

  localparam int NSEG = 64;

  // A request kind that the block must ignore.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] addr;
    logic        moved;
    logic [16:0] copy;
  } alloc_reply_t;

  // Scoreboard: a software copy of the allocator and the queue of replies
  // still owed by the block.
  class alloc_scoreboard;
    int unsigned seg_off[NSEG];
    int unsigned seg_size[NSEG];
    bit          seg_free[NSEG];
    int unsigned seg_count;
    int unsigned top;
    int unsigned hdr;
    int unsigned lim;
    alloc_reply_t owed[$];
    int errors;

    function void clear();
      seg_count = 0;
      top = 0;
      hdr = ffsa_pkg::HEADER_RST;
      lim = ffsa_pkg::LIMIT_RST;
      errors = 0;
    endfunction

    function void write_reg(logic idx, int unsigned val);
      if (idx == ffsa_pkg::CFG_HEADER) hdr = val & 32'h7f;
      else lim = val & 32'h1ffff;
    endfunction

    function void open_at(int unsigned p);
      for (int unsigned k = seg_count; k > p; k--) begin
        seg_off[k] = seg_off[k-1];
        seg_size[k] = seg_size[k-1];
        seg_free[k] = seg_free[k-1];
      end
      seg_count++;
    endfunction

    function void close_at(int unsigned p);
      for (int unsigned k = p; k + 1 < seg_count; k++) begin
        seg_off[k] = seg_off[k+1];
        seg_size[k] = seg_size[k+1];
        seg_free[k] = seg_free[k+1];
      end
      seg_count--;
    endfunction

    function void merge_next(int unsigned p);
      seg_size[p] = (seg_size[p] + hdr + seg_size[p+1]) & 32'h1ffff;
      close_at(p + 1);
    endfunction

    function void drop_free_top();
      int unsigned o;
      while (seg_count > 0 && seg_free[seg_count-1]) begin
        o = seg_off[seg_count-1];
        top = (o > hdr) ? o - hdr : 0;
        seg_count--;
      end
    endfunction

    function int find_in_use(int unsigned a);
      for (int unsigned i = 0; i < seg_count; i++)
        if (!seg_free[i] && seg_off[i] == a) return int'(i);
      return -1;
    endfunction

    function void take(int unsigned i, int unsigned req);
      int unsigned diff;
      diff = seg_size[i] - req;
      seg_free[i] = 0;
      if (diff > hdr && seg_count < NSEG) begin
        seg_size[i] = req;
        open_at(i + 1);
        seg_off[i+1] = (seg_off[i] + req + hdr) & 32'hffff;
        seg_size[i+1] = diff - hdr;
        seg_free[i+1] = 1;
        if (i + 2 < seg_count && seg_free[i+2]) merge_next(i + 1);
        drop_free_top();
      end
    endfunction

    function logic [2:0] first_fit(int unsigned req, output int unsigned a);
      longint unsigned need;
      int unsigned cap;
      a = 0;
      if (req == 0) return ffsa_pkg::ST_ZERO;
      for (int unsigned i = 0; i < seg_count; i++)
        if (seg_free[i] && seg_size[i] >= req) begin
          take(i, req);
          a = seg_off[i];
          return ffsa_pkg::ST_OK;
        end
      if (seg_count >= NSEG) return ffsa_pkg::ST_FULL;
      cap = (lim > 65536) ? 65536 : lim;
      need = longint'(top) + hdr + req;
      if (need > cap) return ffsa_pkg::ST_NOSPACE;
      seg_off[seg_count] = (top + hdr) & 32'hffff;
      seg_size[seg_count] = req;
      seg_free[seg_count] = 0;
      a = seg_off[seg_count];
      seg_count++;
      top = 32'(need);
      return ffsa_pkg::ST_OK;
    endfunction

    function void release_at(int unsigned i);
      seg_free[i] = 1;
      if (i + 1 < seg_count && seg_free[i+1]) merge_next(i);
      if (i > 0 && seg_free[i-1]) merge_next(i - 1);
      drop_free_top();
    endfunction

    // Note an accepted request beat and queue the reply it must produce.
    function void note_request(logic [1:0] kind, int unsigned req, bit has,
                               int unsigned a);
      alloc_reply_t r;
      int idx;
      int unsigned fresh, old_size;
      r = '{status: ffsa_pkg::ST_OK, addr: '0, moved: 1'b0, copy: '0};
      if (kind == ffsa_pkg::KIND_ALLOC) begin
        r.status = first_fit(req, fresh);
        r.addr = 16'(fresh);
      end else if (kind == ffsa_pkg::KIND_FREE) begin
        if (has) begin
          idx = find_in_use(a);
          if (idx < 0) r.status = ffsa_pkg::ST_BADADDR;
          else release_at(unsigned'(idx));
        end
      end else if (kind == ffsa_pkg::KIND_REALLOC) begin
        if (!has) begin
          r.status = first_fit(req, fresh);
          r.addr = 16'(fresh);
        end else begin
          idx = find_in_use(a);
          if (idx < 0) r.status = ffsa_pkg::ST_BADADDR;
          else if (req == 0) begin
            r.status = ffsa_pkg::ST_ZERO;
            r.addr = 16'(a);
          end else if (req <= seg_size[idx]) begin
            take(unsigned'(idx), req);
            r.addr = 16'(a);
          end else begin
            old_size = seg_size[idx];
            r.status = first_fit(req, fresh);
            if (r.status != ffsa_pkg::ST_OK) r.addr = 16'(a);
            else begin
              idx = find_in_use(a);
              if (idx >= 0) release_at(unsigned'(idx));
              r.addr = 16'(fresh);
              r.moved = 1'b1;
              r.copy = 17'(old_size);
            end
          end
        end
      end
      owed.push_back(r);
    endfunction

    // Compare one result beat with the oldest owed reply.
    function void check_reply(alloc_reply_t got);
      alloc_reply_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d addr=%0d", $time,
                 got.status, got.addr);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.addr !== e.addr) begin
        $display("%0t: result_address expected %0d actual %0d", $time, e.addr,
                 got.addr);
        errors++;
      end
      if (got.moved !== e.moved) begin
        $display("%0t: moved expected %0d actual %0d", $time, e.moved, got.moved);
        errors++;
      end
      if (got.copy !== e.copy) begin
        $display("%0t: copy_bytes expected %0d actual %0d", $time, e.copy, got.copy);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [16:0] in_request_size;
  logic        in_has_address;
  logic [15:0] in_block_address;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [15:0] out_result_address;
  logic        out_moved;
  logic [16:0] out_copy_bytes;
  logic        cfg_we;
  logic        cfg_index;
  logic [16:0] cfg_wdata;

  alloc_scoreboard sb;
  bit calm;          // no idling on either side
  int unsigned granted[$];   // addresses believed to be live

  first_fit_segment_allocator dut (.*);

  // Clock: 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Result side: random stall bursts, and checking at the rising edge.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 8);
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_reply('{status: out_status, addr: out_result_address,
                       moved: out_moved, copy: out_copy_bytes});
  end

  // Note requests at the edge they are accepted.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request(in_kind, in_request_size, in_has_address, in_block_address);
  end

  // Send one request beat and wait for its acceptance.
  task automatic send_request(logic [1:0] kind, int unsigned req, bit has,
                              int unsigned a);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_request_size = 17'(req);
    in_has_address = has;
    in_block_address = 16'(a);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Wait until every owed reply has arrived, then stay idle for a while.
  task automatic drain();
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = 17'(val);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Pick an address: mostly one handed out earlier, sometimes any value.
  function automatic int unsigned pick_addr();
    if (granted.size() != 0 && $urandom_range(0, 9) < 8)
      return granted[$urandom_range(0, granted.size() - 1)];
    return $urandom_range(0, 65535);
  endfunction

  // Random size: mostly small, a few up to the full field.
  function automatic int unsigned pick_size();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(0, 131071);
      2, 3:    return $urandom_range(0, 4096);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  task automatic random_phase(int count);
    int unsigned k, a;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 19);
      a = pick_addr();
      if (k < 8) send_request(ffsa_pkg::KIND_ALLOC, pick_size(), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 65535));
      else if (k < 14) send_request(ffsa_pkg::KIND_FREE, pick_size(),
                                    $urandom_range(0, 9) != 0, a);
      else if (k < 19) send_request(ffsa_pkg::KIND_REALLOC, pick_size(),
                                    $urandom_range(0, 9) != 0, a);
      else send_request(KIND_UNUSED, pick_size(), 1'($urandom_range(0, 1)), a);
    end
  endtask

  // Track live addresses from the result stream.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_status == ffsa_pkg::ST_OK
        && out_result_address != 0 && granted.size() < 200)
      granted.push_back(out_result_address);
  end

  initial begin
    sb = new();
    sb.clear();
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = ffsa_pkg::KIND_ALLOC;
    in_request_size = '0;
    in_has_address = 1'b0;
    in_block_address = '0;
    cfg_we = 1'b0;
    cfg_index = ffsa_pkg::CFG_HEADER;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: edge sizes, every kind, zero sizes, null and bad addresses.
    send_request(ffsa_pkg::KIND_ALLOC, 0, 0, 0);
    send_request(ffsa_pkg::KIND_ALLOC, 100, 0, 0);
    send_request(ffsa_pkg::KIND_ALLOC, 200, 0, 0);
    send_request(ffsa_pkg::KIND_ALLOC, 50, 0, 0);
    send_request(ffsa_pkg::KIND_ALLOC, 131071, 0, 0);
    send_request(ffsa_pkg::KIND_FREE, 0, 0, 0);
    send_request(ffsa_pkg::KIND_FREE, 0, 1, 16'hffff);
    send_request(ffsa_pkg::KIND_FREE, 0, 1, 132);
    send_request(ffsa_pkg::KIND_ALLOC, 60, 0, 0);
    send_request(ffsa_pkg::KIND_REALLOC, 0, 1, 16);
    send_request(ffsa_pkg::KIND_REALLOC, 40, 1, 16);
    send_request(ffsa_pkg::KIND_REALLOC, 1000, 1, 16);
    send_request(ffsa_pkg::KIND_REALLOC, 70000, 1, 348);
    send_request(ffsa_pkg::KIND_REALLOC, 30, 0, 0);
    send_request(ffsa_pkg::KIND_REALLOC, 0, 0, 0);
    send_request(ffsa_pkg::KIND_REALLOC, 5, 1, 7);
    send_request(KIND_UNUSED, 17'h1ffff, 1, 16'hffff);
    send_request(ffsa_pkg::KIND_FREE, 0, 1, 348);
    send_request(ffsa_pkg::KIND_ALLOC, 65536, 0, 0);
    drain();

    // Configuration sweep with random traffic at each setting.
    write_reg(ffsa_pkg::CFG_HEADER, 1);
    write_reg(ffsa_pkg::CFG_LIMIT, 0);
    random_phase(60);
    drain();
    write_reg(ffsa_pkg::CFG_LIMIT, 131071);
    write_reg(ffsa_pkg::CFG_HEADER, 64);
    random_phase(200);
    drain();
    write_reg(ffsa_pkg::CFG_LIMIT, 4000);
    write_reg(ffsa_pkg::CFG_HEADER, 8);
    random_phase(250);
    drain();
    write_reg(ffsa_pkg::CFG_HEADER, 127);
    random_phase(100);
    drain();
    write_reg(ffsa_pkg::CFG_HEADER, 16);
    write_reg(ffsa_pkg::CFG_LIMIT, 65536);
    random_phase(150);
    calm = 1'b1;
    random_phase(190);
    drain();

    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("first_fit_segment_allocator: match");
    else
      $display("first_fit_segment_allocator: mismatch");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #200ms;
    $display("first_fit_segment_allocator: mismatch");
    $finish;
  end
endmodule
